### rtl/core/smt_pkg.sv
// smt_pkg: shared types for the stream mode tracker
// used by smt_cell, smt_best and the stream_mode_tracker top level

package smt_pkg;

  localparam int unsigned ValueBits = 32;
  localparam int unsigned OutCountBits = 16;

  // control and key of one beat as it walks down the cell chain
  typedef struct packed {
    logic                 valid;
    logic                 last;
    logic                 done;   // a cell has already counted this beat
    logic [ValueBits-1:0] value;
  } token_t;

endpackage

### rtl/core/smt_cell.sv
// smt_cell: one table entry of the chain, a key and its occurrence count
// depends on smt_pkg for the token type

module smt_cell #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  smt_pkg::token_t       tin,
  input  logic [COUNT_BITS-1:0] cin,
  output smt_pkg::token_t       tout,
  output logic [COUNT_BITS-1:0] cout
);

  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  logic [smt_pkg::ValueBits-1:0] key;
  logic [COUNT_BITS-1:0]         count;
  logic                          live;
  logic                          free;
  logic                          match;
  logic                          take;
  logic [COUNT_BITS-1:0]         count_next;

  assign live  = tin.valid && !tin.done;
  assign free  = (count == '0);
  assign match = !free && (key == tin.value);
  // occupied entries always form a prefix, so the first free cell ends the search
  assign take  = live && (match || free);

  always_comb begin
    if (free) begin
      count_next = COUNT_BITS'(1);
    end else if (count == CountMax) begin
      count_next = count;
    end else begin
      count_next = count + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (adv && tin.valid && tin.last) begin
      count <= '0;
    end else if (adv && take) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && take && free) begin
      key <= tin.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tout.valid <= 1'b0;
    end else if (adv) begin
      tout.valid <= tin.valid;
    end
    if (adv) begin
      tout.last  <= tin.last;
      tout.value <= tin.value;
      tout.done  <= tin.done || take;
      cout       <= take ? count_next : cin;
    end
  end

endmodule

### rtl/core/smt_best.sv
// smt_best: running best tracker and output register at the end of the chain
// depends on smt_pkg for the token type and output widths

module smt_best #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 adv,
  input  smt_pkg::token_t                      tin,
  input  logic [COUNT_BITS-1:0]                cin,
  output logic                                 out_valid,
  output logic [smt_pkg::ValueBits-1:0]        mode_value,
  output logic [smt_pkg::OutCountBits-1:0]     mode_count,
  output logic                                 table_overflow,
  output logic                                 set_done
);

  localparam int unsigned WideBits =
    (COUNT_BITS > smt_pkg::OutCountBits) ? COUNT_BITS : smt_pkg::OutCountBits;
  localparam logic [WideBits-1:0] OutMax = WideBits'({smt_pkg::OutCountBits{1'b1}});

  logic [smt_pkg::ValueBits-1:0] best_value;
  logic [COUNT_BITS-1:0]         best_count;
  logic [smt_pkg::ValueBits-1:0] best_value_next;
  logic [COUNT_BITS-1:0]         best_count_next;
  logic [WideBits-1:0]           count_wide;

  always_comb begin
    best_value_next = best_value;
    best_count_next = best_count;
    if (tin.done && (cin > best_count)) begin
      best_value_next = tin.value;
      best_count_next = cin;
    end
    count_wide = WideBits'(best_count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      best_value <= '0;
      best_count <= '0;
    end else if (adv) begin
      out_valid <= tin.valid;
      if (tin.valid) begin
        best_value <= tin.last ? '0 : best_value_next;
        best_count <= tin.last ? '0 : best_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tin.valid) begin
      mode_value     <= best_value_next;
      mode_count     <= (count_wide > OutMax) ? smt_pkg::OutCountBits'(OutMax)
                                              : count_wide[smt_pkg::OutCountBits-1:0];
      table_overflow <= !tin.done;
      set_done       <= tin.last;
    end
  end

endmodule

### rtl/core/stream_mode_tracker.sv
// stream_mode_tracker: most frequent value of each set on a beat stream
// depends on smt_pkg, smt_cell and smt_best
//
//  channel | dir | tdata                               | tuser             | tlast
//  s_*     | in  | [31:0] value                        | -                 | last
//  m_*     | out | [31:0] mode_value, [47:32] mode_cnt | [0] table_overflow| set_done
//
// each beat walks the row of TABLE_ENTRIES cells, one cell per cycle while the chain
// advances, and then through the output register of smt_best; a new beat enters every
// cycle unless the chain holds
// the whole chain advances together and holds while a result waits on m_tready
// reset clears every cell count and the best at once; no clearing pass
// after a beat with tlast each cell frees itself as that beat passes it

module stream_mode_tracker #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned COUNT_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [31:0] mode_value, [47:32] mode_count
  output logic [0:0]  m_tuser,   // [0] table_overflow
  output logic        m_tlast
);

  logic                  adv;
  smt_pkg::token_t       tok [TABLE_ENTRIES+1];
  logic [COUNT_BITS-1:0] cnt [TABLE_ENTRIES+1];
  logic [31:0]           mode_value;
  logic [15:0]           mode_count;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_comb begin
    tok[0].valid = s_tvalid;
    tok[0].last  = s_tlast;
    tok[0].done  = 1'b0;
    tok[0].value = s_tdata;
    cnt[0]       = '0;
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    smt_cell #(
      .COUNT_BITS(COUNT_BITS)
    ) u_cell (
      .clk (clk),
      .rst (rst),
      .adv (adv),
      .tin (tok[i]),
      .cin (cnt[i]),
      .tout(tok[i+1]),
      .cout(cnt[i+1])
    );
  end

  smt_best #(
    .COUNT_BITS(COUNT_BITS)
  ) u_best (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .tin           (tok[TABLE_ENTRIES]),
    .cin           (cnt[TABLE_ENTRIES]),
    .out_valid     (m_tvalid),
    .mode_value    (mode_value),
    .mode_count    (mode_count),
    .table_overflow(m_tuser[0]),
    .set_done      (m_tlast)
  );

  assign m_tdata = {mode_count, mode_value};

endmodule

### rtl/core/smt_checker.sv
// smt_checker: port-level checks on the stream mode tracker
// bound to stream_mode_tracker, uses only its ports

module smt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [0:0]  m_tuser,
  input logic        m_tlast
);

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("held result changed");

  // an empty output stage never blocks the input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // a zero count, as before anything in the set was counted, comes with a zero mode value
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[47:32] == 16'd0) |-> (m_tdata[31:0] == 32'd0))
    else $error("nonzero mode value with zero count");

  // a counted beat leaves a nonzero best
  a_counted: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> (m_tdata[47:32] != 16'd0))
    else $error("counted beat with zero best count");

endmodule

bind stream_mode_tracker smt_checker u_smt_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast)
);

### tb/stream_mode_tracker_tb.sv
// stream_mode_tracker_tb: self-checking bench for the stream mode tracker
// drives value beats with random gaps and back-pressure and checks every result beat
// against a table-and-best model; depends on smt_pkg and the stream_mode_tracker rtl

module stream_mode_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_ENTRIES = 64;
  localparam int COUNT_BITS    = 16;
  localparam longint unsigned CountMax = (64'd1 << COUNT_BITS) - 1;
  localparam int RandomBeats   = 1500;
  localparam int CycleLimit    = 1_000_000;
  localparam int MaxReports    = 20;

  typedef struct packed {
    logic [smt_pkg::ValueBits-1:0]    mode_value;
    logic [smt_pkg::OutCountBits-1:0] mode_count;
    logic                             overflow;
    logic                             done;
  } mode_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] value
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // [31:0] mode_value, [47:32] mode_count
  logic [0:0]  m_tuser;        // [0] table_overflow
  logic        m_tlast;

  stream_mode_tracker #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .COUNT_BITS   (COUNT_BITS)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  // model of the count table and the running best
  logic [31:0]       tbl_key [TABLE_ENTRIES];
  longint unsigned   tbl_cnt [TABLE_ENTRIES];
  logic [31:0]       top_value;
  longint unsigned   top_count;
  mode_result_t      mode_expected[$];

  int  errors = 0;
  int  beats_sent = 0;
  int  sets_sent = 0;
  int  overflows = 0;
  int  results_seen = 0;
  int  peak_count = 0;
  int  cycles = 0;
  bit  src_idle_en = 1'b1;
  bit  sink_idle_en = 1'b1;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout, %0d results still expected", $time, mode_expected.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom();
    if (r < 8) return 32'($signed($urandom_range(0, 15)) - 8);
    if (r < 9) return 32'h8000_0000 + $urandom_range(0, 3);
    return 32'h7FFF_FFFF - $urandom_range(0, 3);
  endfunction

  function automatic void clear_table();
    for (int i = 0; i < TABLE_ENTRIES; i++) tbl_cnt[i] = 0;
    top_value = '0;
    top_count = 0;
  endfunction

  function automatic void count_value(input logic [31:0] v, input logic fin);
    int hit;
    int free_idx;
    mode_result_t r;
    hit = -1;
    free_idx = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (tbl_cnt[i] != 0) begin
        if (hit < 0 && tbl_key[i] == v) hit = i;
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    r.overflow = 1'b0;
    // lowest free entry takes a new value
    if (hit < 0 && free_idx >= 0) begin
      hit = free_idx;
      tbl_key[hit] = v;
    end
    if (hit < 0) begin
      r.overflow = 1'b1;
      overflows++;
    end else begin
      if (tbl_cnt[hit] < CountMax) tbl_cnt[hit]++;
      // strictly greater, so the earliest value keeps a tie
      if (tbl_cnt[hit] > top_count) begin
        top_count = tbl_cnt[hit];
        top_value = v;
      end
    end
    r.mode_value = top_value;
    r.mode_count = (top_count > 65535) ? 16'hFFFF : 16'(top_count);
    r.done = fin;
    if (int'(r.mode_count) > peak_count) peak_count = int'(r.mode_count);
    mode_expected.insert(mode_expected.size(), r);
    if (fin) begin
      clear_table();
      sets_sent++;
    end
  endfunction

  // entered and left just after a rising edge
  task automatic send_beat(input logic [31:0] v, input logic fin);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    count_value(v, fin);
    beats_sent++;
    gap = src_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result side back-pressure
  initial begin
    int hold;
    hold = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (sink_idle_en && $urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    mode_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (mode_expected.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: unexpected result beat, actual value %h count %0d ovf %b last %b",
                   $time, m_tdata[31:0], m_tdata[47:32], m_tuser[0], m_tlast);
      end else begin
        want = mode_expected.pop_front();
        if (m_tdata[31:0] !== want.mode_value) begin
          errors++;
          if (errors <= MaxReports)
            $display("%0t: mode_value expected %h actual %h", $time, want.mode_value,
                     m_tdata[31:0]);
        end
        if (m_tdata[47:32] !== want.mode_count) begin
          errors++;
          if (errors <= MaxReports)
            $display("%0t: mode_count expected %0d actual %0d", $time, want.mode_count,
                     m_tdata[47:32]);
        end
        if (m_tuser[0] !== want.overflow) begin
          errors++;
          if (errors <= MaxReports)
            $display("%0t: table_overflow expected %b actual %b", $time, want.overflow,
                     m_tuser[0]);
        end
        if (m_tlast !== want.done) begin
          errors++;
          if (errors <= MaxReports)
            $display("%0t: set_done expected %b actual %b", $time, want.done, m_tlast);
        end
      end
    end
  end

  task automatic test_extremes();
    send_beat(32'h8000_0000, 1'b0);
    send_beat(32'h7FFF_FFFF, 1'b0);
    send_beat(32'h7FFF_FFFF, 1'b0);
    send_beat(32'h0000_0000, 1'b0);
    send_beat(32'hFFFF_FFFF, 1'b0);
    send_beat(32'h0000_0000, 1'b0);
    send_beat(32'h0000_0000, 1'b0);
    send_beat(32'hAAAA_AAAA, 1'b0);
    send_beat(32'h5555_5555, 1'b0);
    send_beat(32'h8000_0000, 1'b1);
  endtask

  task automatic test_ties();
    // b passes a only by reaching a higher count first
    send_beat(32'h0000_000A, 1'b0);
    send_beat(32'h0000_000B, 1'b0);
    send_beat(32'h0000_000B, 1'b0);
    send_beat(32'h0000_000A, 1'b0);
    send_beat(32'hFFFF_FFF0, 1'b0);
    send_beat(32'hFFFF_FFF0, 1'b0);
    send_beat(32'hFFFF_FFF0, 1'b1);
    send_beat(32'h0000_000A, 1'b0);
    send_beat(32'h0000_000B, 1'b0);
    send_beat(32'h0000_000A, 1'b0);
    send_beat(32'h0000_000B, 1'b1);
  endtask

  task automatic test_single_sets();
    repeat (4) send_beat($urandom(), 1'b1);
  endtask

  task automatic test_table_full();
    for (int i = 0; i < TABLE_ENTRIES; i++) send_beat(32'hC000_0000 | i, 1'b0);
    // new values now find no free entry
    for (int k = 0; k < 3; k++) send_beat(32'h0BAD_0000 + k, 1'b0);
    send_beat(32'hC000_0000 | (TABLE_ENTRIES - 1), 1'b0);
    send_beat(32'h0BAD_00FF, 1'b1);
    // table must be free again
    send_beat(32'h0BAD_0001, 1'b0);
    send_beat(32'h0BAD_0001, 1'b0);
    send_beat(32'h0BAD_0002, 1'b1);
  endtask

  task automatic test_long_run();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    // one value runs its count past eight bits
    repeat (300) send_beat(32'h8000_0001, 1'b0);
    // a second value stays behind it
    repeat (3) send_beat(32'h7FFF_FFFE, 1'b0);
    send_beat(32'h8000_0001, 1'b1);
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  task automatic test_random_sets();
    logic [31:0] pool [128];
    int pool_n;
    int set_len;
    int kind;
    int idx;
    int sent;
    logic fin;
    sent = 0;
    while (sent < RandomBeats) begin
      kind = $urandom_range(0, 9);
      src_idle_en  = ($urandom_range(0, 4) != 0);
      sink_idle_en = ($urandom_range(0, 4) != 0);
      if (kind < 6) begin
        pool_n  = $urandom_range(1, 10);
        set_len = $urandom_range(1, 60);
      end else if (kind < 8) begin
        // pools of 50 to 90 values, which can hold more distinct values than the table holds
        pool_n  = $urandom_range(50, 90);
        set_len = $urandom_range(60, 140);
      end else begin
        pool_n  = 0;
        set_len = $urandom_range(1, 4);
      end
      for (int i = 0; i < pool_n; i++) pool[i] = pick_value();
      for (int j = 0; j < set_len; j++) begin
        if (pool_n > 0) begin
          idx = $urandom_range(0, pool_n - 1);
          if ($urandom_range(0, 1) == 1) idx = idx / 2;
          fin = (j == set_len - 1);
          send_beat(pool[idx], fin);
        end else begin
          fin = 1'($urandom_range(0, 1));
          send_beat(pick_value(), fin);
        end
        sent++;
      end
    end
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  initial begin
    clear_table();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_ties();
    test_single_sets();
    test_table_full();
    test_long_run();
    test_random_sets();
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
    while (mode_expected.size() != 0) @(posedge clk);
    repeat (TABLE_ENTRIES + 16) @(posedge clk);
    $display("sent %0d beats in %0d sets, %0d table overflows, peak mode count %0d",
             beats_sent, sets_sent, overflows, peak_count);
    $display("checked %0d result beats, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
